/* hw/rtl/ppss_pkg.sv */
// Package for the pump pre-infusion shot sequencer.
// Holds widths, phase codes, configuration and state types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppss_pkg;

    localparam int TIME_BITS = 32;
    localparam int PRE_W     = 14;
    localparam int FILL_W    = 11;
    localparam int EXTR_W    = 17;
    localparam int REM_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_ON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_MS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTR_MS = 2'd3;

    // Reset values of the configuration registers
    localparam logic              RST_PRE_ON  = 1'b1;
    localparam logic [PRE_W-1:0]  RST_PRE_MS  = 14'd5000;
    localparam logic [FILL_W-1:0] RST_FILL_MS = 11'd1000;
    localparam logic [EXTR_W-1:0] RST_EXTR_MS = 17'd30000;

    // Phase codes as seen on the result port
    localparam logic [1:0] PC_IDLE = 2'd0;
    localparam logic [1:0] PC_PRE  = 2'd1;
    localparam logic [1:0] PC_BREW = 2'd2;
    localparam logic [1:0] PC_STOP = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_PRE  = 4'b0010,
        PH_BREW = 4'b0100,
        PH_STOP = 4'b1000
    } t_phase;

    typedef struct packed {
        logic              pre_on;
        logic [PRE_W-1:0]  pre_ms;
        logic [FILL_W-1:0] fill_ms;
        logic [EXTR_W-1:0] extr_ms;
    } t_cfg;

    typedef struct packed {
        t_phase               phase;
        logic                 relay;
        logic [TIME_BITS-1:0] start;
        logic                 fill_done;
    } t_state;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        case (ph)
            PH_IDLE: code = PC_IDLE;
            PH_PRE:  code = PC_PRE;
            PH_BREW: code = PC_BREW;
            PH_STOP: code = PC_STOP;
            default: code = PC_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ppss_step.sv */
// Next-state and remaining-time logic for one shot sequencer word.
// Depends on ppss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppss_step
    import ppss_pkg::*;
(
    input  var t_cfg                 i_cfg,
    input  var t_state               i_state,
    input  wire                      i_switch_level,
    input  wire  [TIME_BITS-1:0]     i_now_ms,
    output t_state                   o_state,
    output logic [REM_W-1:0]         o_remaining_ms
);

    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] elapsed_after;
    logic                 restart;

    assign elapsed = i_now_ms - i_state.start;

    always_comb begin
        o_state = i_state;
        restart = 1'b0;
        case (i_state.phase)
            PH_IDLE: begin
                if (i_switch_level) begin
                    o_state.start     = i_now_ms;
                    o_state.fill_done = 1'b0;
                    o_state.relay     = 1'b1;
                    o_state.phase     = PH_PRE;
                    restart           = 1'b1;
                end
            end
            PH_PRE: begin
                // time up or disabled wins over release, release over fill end
                if (!i_cfg.pre_on || elapsed >= TIME_BITS'(i_cfg.pre_ms)) begin
                    o_state.start = i_now_ms;
                    o_state.relay = 1'b1;
                    o_state.phase = PH_BREW;
                    restart       = 1'b1;
                end else if (!i_switch_level) begin
                    o_state.relay = 1'b0;
                    o_state.phase = PH_STOP;
                end else if (elapsed >= TIME_BITS'(i_cfg.fill_ms) && !i_state.fill_done) begin
                    o_state.relay     = 1'b0;
                    o_state.fill_done = 1'b1;
                end
            end
            PH_BREW: begin
                if (!i_switch_level || elapsed >= TIME_BITS'(i_cfg.extr_ms)) begin
                    o_state.relay = 1'b0;
                    o_state.phase = PH_STOP;
                end
            end
            PH_STOP: begin
                if (!i_switch_level) begin
                    o_state.phase = PH_IDLE;
                end
            end
            default: begin
                o_state.phase = PH_IDLE;
                o_state.relay = 1'b0;
            end
        endcase
    end

    assign elapsed_after = restart ? '0 : elapsed;

    // Count down within the pre and brew phases, saturate at zero; other phases show the extraction time
    always_comb begin
        case (o_state.phase)
            PH_PRE: begin
                if (elapsed_after < TIME_BITS'(i_cfg.pre_ms)) begin
                    o_remaining_ms = REM_W'(i_cfg.pre_ms - elapsed_after[PRE_W-1:0]);
                end else begin
                    o_remaining_ms = '0;
                end
            end
            PH_BREW: begin
                if (elapsed_after < TIME_BITS'(i_cfg.extr_ms)) begin
                    o_remaining_ms = REM_W'(i_cfg.extr_ms - elapsed_after[EXTR_W-1:0]);
                end else begin
                    o_remaining_ms = '0;
                end
            end
            default: o_remaining_ms = REM_W'(i_cfg.extr_ms);
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/pump_preinfusion_shot_sequencer_unit.sv */
// Top level of the pump pre-infusion shot sequencer: handshake, config and state registers.
// Depends on ppss_pkg and ppss_step.
//
//  Channel | Direction | Handshake                 | Word
//  --------+-----------+---------------------------+-------------------------------------
//  in      | into unit | i_in_valid / o_in_stall   | i_switch_level, i_now_ms
//  out     | from unit | o_out_valid / i_out_stall | o_relay_on, o_phase, o_remaining_ms
//  cfg     | into unit | i_cfg_we                  | i_cfg_index, i_cfg_wdata
//
// Each word is taken into the input register, passes the step logic and lands in the
// result register; one word per cycle is sustained while the output is not stalled.
// The combinational step logic and the phase state register close one loop.
// Synchronous active-low reset clears phase, relay, timer and fill flag and reloads
// the config defaults.
// A stall on the output holds the result; the input register fills once more,
// then o_in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module pump_preinfusion_shot_sequencer_unit
    import ppss_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DAT_W-1:0]  i_cfg_wdata,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire                   i_switch_level,
    input  wire  [TIME_BITS-1:0]  i_now_ms,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic                  o_relay_on,
    output logic [1:0]            o_phase,
    output logic [REM_W-1:0]      o_remaining_ms
);

    t_cfg                 r_cfg;
    t_state               r_state;
    t_state               n_state;
    logic                 r_in_valid;
    logic                 r_in_switch;
    logic [TIME_BITS-1:0] r_in_now;
    logic                 r_out_valid;
    logic                 r_relay;
    logic [1:0]           r_phase;
    logic [REM_W-1:0]     r_rem;
    logic [REM_W-1:0]     n_rem;
    logic                 out_free;
    logic                 advance;
    logic                 in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    ppss_step u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_switch_level (r_in_switch),
        .i_now_ms       (r_in_now),
        .o_state        (n_state),
        .o_remaining_ms (n_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_on  <= RST_PRE_ON;
            r_cfg.pre_ms  <= RST_PRE_MS;
            r_cfg.fill_ms <= RST_FILL_MS;
            r_cfg.extr_ms <= RST_EXTR_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRE_ON:  r_cfg.pre_on  <= i_cfg_wdata[0];
                CFG_PRE_MS:  r_cfg.pre_ms  <= i_cfg_wdata[PRE_W-1:0];
                CFG_FILL_MS: r_cfg.fill_ms <= i_cfg_wdata[FILL_W-1:0];
                CFG_EXTR_MS: r_cfg.extr_ms <= i_cfg_wdata[EXTR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_state.phase     <= PH_IDLE;
            r_state.relay     <= 1'b0;
            r_state.start     <= '0;
            r_state.fill_done <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_switch <= i_switch_level;
            r_in_now    <= i_now_ms;
        end
        if (advance) begin
            r_relay <= n_state.relay;
            r_phase <= phase_code(n_state.phase);
            r_rem   <= n_rem;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_relay_on     = r_relay;
    assign o_phase        = r_phase;
    assign o_remaining_ms = r_rem;

`ifndef SYNTHESIS
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state.phase))
        else $error("phase register lost its one-hot code");

    a_idle_relay_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_IDLE || r_state.phase == PH_STOP) |-> !r_state.relay)
        else $error("relay on while idle or stopped");

    a_brew_relay_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_phase == PC_BREW) |-> o_relay_on)
        else $error("brewing word shows relay off");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("word advanced but no result valid");
`endif

endmodule

`default_nettype wire
